### sv/rgbc_pkg.sv
// Shared types and constants for the RGB 3x3 convolution block.
package rgbc_pkg;

    localparam int CFG_DIM_W  = 11;
    localparam int CFG_DIV_W  = 8;
    localparam int CFG_COEF_W = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int TAP_W      = 16;
    localparam int NUM_TAPS   = 9;
    localparam int POS_W      = 10;
    localparam int SUM_W      = 28;
    localparam int QUO_W      = 27;
    localparam int PROD_W     = TAP_W + CH_W + 1;
    localparam int MAX_HEIGHT = 1024;
    localparam int CLAMP_MAX  = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_DIVISOR = 3'd2,
        CFG_COEF0   = 3'd3,
        CFG_COEF1   = 3'd4,
        CFG_COEF2   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        C_IDLE,
        C_WIN,
        C_CALC
    } t_ctl_state;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAC,
        F_DIV,
        F_DONE
    } t_flt_state;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_flt_result;

endpackage

### sv/rgbc_line_mem.sv
// Synchronous line store memory holding the two previous rows for each column.
module rgbc_line_mem
    import rgbc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [2*PIX_W-1:0]         i_wr_data,
    output logic [2*PIX_W-1:0]         o_rd_data
);

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/rgbc_filter.sv
// Multiply-accumulate over the nine taps followed by a serial divider and clamp.
module rgbc_filter
    import rgbc_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_ack,
    input  logic [NUM_TAPS-1:0][PIX_W-1:0]   i_window,
    input  logic [NUM_TAPS-1:0][TAP_W-1:0]   i_taps,
    input  logic [CFG_DIV_W-1:0]             i_divisor,
    output t_flt_result                      o_res
);

    t_flt_state r_state;
    t_flt_state n_state;

    logic [3:0]                     r_idx;
    logic [4:0]                     r_cnt;
    logic signed [SUM_W-1:0]        r_acc [3];
    logic [CFG_DIV_W-1:0]           r_rem [3];
    logic [QUO_W-1:0]               r_quo [3];
    logic signed [SUM_W-1:0]        n_acc [3];
    logic [PIX_W-1:0]               w_pix;
    logic signed [TAP_W-1:0]        w_tap;
    logic signed [PROD_W-1:0]       w_prod [3];
    logic [CH_W:0]                  w_trial [3];
    logic [CH_W-1:0]                w_clamp [3];

    assign w_pix = i_window[r_idx];
    assign w_tap = $signed(i_taps[r_idx]);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_prod[ch] = PROD_W'(w_tap * $signed({1'b0, w_pix[ch*CH_W +: CH_W]}));
            n_acc[ch] = r_acc[ch] + SUM_W'(w_prod[ch]);
            w_trial[ch] = {r_rem[ch], r_quo[ch][QUO_W-1]};
            w_clamp[ch] = (r_quo[ch] > QUO_W'(CLAMP_MAX)) ? CH_W'(CLAMP_MAX)
                                                           : r_quo[ch][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = F_MAC;
                end
            end
            F_MAC: begin
                if (r_idx == 4'(NUM_TAPS - 1)) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == 5'(QUO_W - 1)) begin
                    n_state = F_DONE;
                end
            end
            F_DONE: begin
                if (i_ack) begin
                    n_state = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_idx <= '0;
                r_cnt <= '0;
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= '0;
                end
            end
            F_MAC: begin
                r_idx <= r_idx + 4'd1;
                for (int ch = 0; ch < 3; ch++) begin
                    r_acc[ch] <= n_acc[ch];
                    r_rem[ch] <= '0;
                    r_quo[ch] <= n_acc[ch][SUM_W-1] ? '0 : n_acc[ch][QUO_W-1:0];
                end
            end
            F_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                for (int ch = 0; ch < 3; ch++) begin
                    if (w_trial[ch] >= {1'b0, i_divisor}) begin
                        r_rem[ch] <= CFG_DIV_W'(w_trial[ch] - {1'b0, i_divisor});
                        r_quo[ch] <= {r_quo[ch][QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem[ch] <= w_trial[ch][CFG_DIV_W-1:0];
                        r_quo[ch] <= {r_quo[ch][QUO_W-2:0], 1'b0};
                    end
                end
            end
            F_DONE: begin
                r_idx <= '0;
            end
        endcase
    end

    assign o_res.done  = (r_state == F_DONE);
    assign o_res.red   = w_clamp[0];
    assign o_res.green = w_clamp[1];
    assign o_res.blue  = w_clamp[2];

endmodule

### sv/rgb_convolution_3x3_clamp.sv
// Top level of the RGB 3x3 convolution with divide and clamp.
//
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_pixel_red, i_pixel_green, i_pixel_blue
// out     | output    | o_out_valid / i_out_ready | o_out_red/green/blue, o_out_row, o_out_col
// cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A border pixel passes through the line store read and then the write-back.
// An interior pixel also goes through the shared multiply-accumulate over the
// nine taps and the 27-bit bit-serial divider before the result is handed over.
// Reset is synchronous and active low; the line store is not cleared.
// A waiting result sits in the output register while the next pixel is taken.
module rgb_convolution_3x3_clamp
    import rgbc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CH_W-1:0]       i_pixel_red,
    input  logic [CH_W-1:0]       i_pixel_green,
    input  logic [CH_W-1:0]       i_pixel_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CH_W-1:0]       o_out_red,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_blue,
    output logic [POS_W-1:0]      o_out_row,
    output logic [POS_W-1:0]      o_out_col,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EFF_W = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;

    logic [CFG_DIM_W-1:0]  r_frame_width;
    logic [CFG_DIM_W-1:0]  r_frame_height;
    logic [CFG_DIV_W-1:0]  r_divisor;
    logic [CFG_COEF_W-1:0] r_coef [3];

    t_ctl_state r_state;
    t_ctl_state n_state;

    logic [COL_W-1:0]                 r_col;
    logic [POS_W-1:0]                 r_row;
    logic [PIX_W-1:0]                 r_pix;
    logic [NUM_TAPS-1:0][PIX_W-1:0]   r_win;
    logic [POS_W-1:0]                 r_res_row;
    logic [POS_W-1:0]                 r_res_col;
    logic                             r_out_valid;
    logic [CH_W-1:0]                  r_out_red;
    logic [CH_W-1:0]                  r_out_green;
    logic [CH_W-1:0]                  r_out_blue;

    logic                             w_accept;
    logic                             w_interior;
    logic                             w_load;
    logic                             w_start;
    logic [EFF_W-1:0]                 w_eff_width;
    logic [CFG_DIM_W-1:0]             w_eff_height;
    logic [CFG_DIV_W-1:0]             w_eff_div;
    logic [2*PIX_W-1:0]               w_rd_data;
    logic [NUM_TAPS-1:0][TAP_W-1:0]   w_taps;
    logic [31:0]                      w_col_m1;
    t_flt_result                      w_flt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_W'(1024);
            r_frame_height <= CFG_DIM_W'(1024);
            r_divisor      <= CFG_DIV_W'(1);
            r_coef[0]      <= '0;
            r_coef[1]      <= CFG_COEF_W'(65536);
            r_coef[2]      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:   r_frame_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT:  r_frame_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_DIVISOR: r_divisor      <= i_cfg_data[CFG_DIV_W-1:0];
                CFG_COEF0:   r_coef[0]      <= i_cfg_data[CFG_COEF_W-1:0];
                CFG_COEF1:   r_coef[1]      <= i_cfg_data[CFG_COEF_W-1:0];
                CFG_COEF2:   r_coef[2]      <= i_cfg_data[CFG_COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (EFF_W'(r_frame_width) < EFF_W'(3)) begin
            w_eff_width = EFF_W'(3);
        end else if (EFF_W'(r_frame_width) > EFF_W'(MAX_WIDTH)) begin
            w_eff_width = EFF_W'(MAX_WIDTH);
        end else begin
            w_eff_width = EFF_W'(r_frame_width);
        end
        if (r_frame_height < CFG_DIM_W'(3)) begin
            w_eff_height = CFG_DIM_W'(3);
        end else if (r_frame_height > CFG_DIM_W'(MAX_HEIGHT)) begin
            w_eff_height = CFG_DIM_W'(MAX_HEIGHT);
        end else begin
            w_eff_height = r_frame_height;
        end
        w_eff_div = (r_divisor == '0) ? CFG_DIV_W'(1) : r_divisor;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_taps[i*3+j] = r_coef[i][j*TAP_W +: TAP_W];
            end
        end
    end

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_interior = (r_row >= POS_W'(2)) && (COL_W'(2) <= r_col);
    assign w_start    = (r_state == C_WIN) && w_interior;
    assign w_load     = (r_state == C_CALC) && w_flt.done && (!r_out_valid || i_out_ready);

    rgbc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_wr_en   (r_state == C_WIN),
        .i_addr    (r_col),
        .i_wr_data ({w_rd_data[PIX_W-1:0], r_pix}),
        .o_rd_data (w_rd_data)
    );

    rgbc_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_ack     (w_load),
        .i_window  (r_win),
        .i_taps    (w_taps),
        .i_divisor (w_eff_div),
        .o_res     (w_flt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (w_accept) begin
                    n_state = C_WIN;
                end
            end
            C_WIN: begin
                n_state = w_interior ? C_CALC : C_IDLE;
            end
            C_CALC: begin
                if (w_load) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == C_WIN) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= w_rd_data[2*PIX_W-1:PIX_W];
                r_win[5] <= w_rd_data[PIX_W-1:0];
                r_win[8] <= r_pix;
                if (EFF_W'(r_col) + EFF_W'(1) >= w_eff_width) begin
                    r_col <= '0;
                    if (CFG_DIM_W'(r_row) + CFG_DIM_W'(1) >= w_eff_height) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + POS_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_col_m1 = 32'(r_col) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= {i_pixel_blue, i_pixel_green, i_pixel_red};
        end
        if (r_state == C_WIN) begin
            r_res_row <= r_row - POS_W'(1);
            r_res_col <= w_col_m1[POS_W-1:0];
        end
        if (w_load) begin
            r_out_red   <= w_flt.red;
            r_out_green <= w_flt.green;
            r_out_blue  <= w_flt.blue;
            o_out_row   <= r_res_row;
            o_out_col   <= r_res_col;
        end
    end

    assign o_in_ready  = (r_state == C_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

`ifndef SYNTH
    a_rise_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == C_CALC)
        else $error("Result appeared without a finished calculation.");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_flt.done)
        else $error("Filter started while holding an unclaimed result.");

    a_accept_to_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == C_WIN)
        else $error("Accepted pixel did not proceed to the write-back cycle.");

    a_load_frees_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !w_flt.done && o_out_valid)
        else $error("Result transfer to the output register went wrong.");
`endif

endmodule
